// ----- hdl/twdt_pkg.sv -----
// Shared constants, codes and tables of the touch wheel direction tracker.
// No dependencies; every other file imports this package.
package twdt_pkg;

  // Default geometry and iteration count
  localparam int COORD_BITS_DEF   = 10;
  localparam int CORDIC_STEPS_DEF = 16;

  // Fixed result widths
  localparam int RAD_BITS = 11;
  localparam int ANG_BITS = 9;
  localparam int EV_BITS  = 3;
  localparam int OP_BITS  = 2;
  localparam int RAD_MAX  = 2047;

  // Packed output: angle_deg, radius_px, zero pad to whole bytes
  localparam int OUT_DATA_BITS = ((ANG_BITS + RAD_BITS + 7) / 8) * 8;

  // Angle arithmetic in 2^-16 scaled degrees
  localparam int FRAC_BITS  = 16;
  localparam int ZW         = 25;
  localparam int QUARTER    = 5898245;
  localparam int HALF       = 11796490;
  localparam int ANGLE_FULL = 360;
  localparam int TAB_LEN    = 24;
  localparam int STEP_BITS  = $clog2(TAB_LEN + 1);

  // round(atan(2^-i) * 57.295827909 * 65536)
  localparam logic [21:0] ATAN_TAB [TAB_LEN] = '{
    22'd2949122, 22'd1740969, 22'd919880, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // Input opcodes
  localparam logic [OP_BITS-1:0] OP_DOWN = 2'd0;
  localparam logic [OP_BITS-1:0] OP_UP   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_MOVE = 2'd2;

  // Item kinds after classification
  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;
  localparam logic [1:0] KIND_NOP  = 2'd3;

  // Wheel event codes
  localparam logic [EV_BITS-1:0] EV_NONE     = 3'd0;
  localparam logic [EV_BITS-1:0] EV_ACTIVE   = 3'd1;
  localparam logic [EV_BITS-1:0] EV_RELEASED = 3'd2;
  localparam logic [EV_BITS-1:0] EV_CW       = 3'd3;
  localparam logic [EV_BITS-1:0] EV_CCW      = 3'd4;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X    = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y    = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RADIUS  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_LINE_Y = 4'd3;

  localparam int CENTER_RESET     = 216;
  localparam int MIN_RADIUS_RESET = 100;
  localparam int WRAP_LINE_RESET  = 216;

  // Items held between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

// ----- hdl/twdt_front.sv -----
// Front end: accepts touch items, classifies the opcode and forms the
// offsets from the wheel center. Depends on twdt_pkg.
module twdt_front import twdt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int ENTRY_BITS = 2 + 2 * COORD_BITS + 2 * (COORD_BITS + 1)
) (
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_DATA_BITS-1:0] s_tdata,
  input  logic [OP_BITS-1:0]      s_tuser,
  input  logic [COORD_BITS-1:0]   center_x,
  input  logic [COORD_BITS-1:0]   center_y,
  input  logic                    q_full,
  output logic                    q_push,
  output logic [ENTRY_BITS-1:0]   q_data
);

  localparam int DW = COORD_BITS + 1;

  logic [COORD_BITS-1:0] px, py;
  logic [DW-1:0]         dx, dy;
  logic [1:0]            kind;

  assign px = s_tdata[COORD_BITS-1:0];
  assign py = s_tdata[2*COORD_BITS-1:COORD_BITS];

  // dx = x - cx, dy = cy - y (screen y flipped)
  assign dx = {1'b0, px} - {1'b0, center_x};
  assign dy = {1'b0, center_y} - {1'b0, py};

  always_comb begin
    case (s_tuser)
      OP_DOWN: kind = KIND_DOWN;
      OP_UP:   kind = KIND_UP;
      OP_MOVE: kind = KIND_MOVE;
      default: kind = KIND_NOP;
    endcase
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_data   = {kind, dy, dx, py, px};

endmodule

// ----- hdl/twdt_queue.sv -----
// Short item queue between front and back ends.
// Depends on twdt_pkg for the default depth.
module twdt_queue import twdt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = (count == CNT_BITS'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/twdt_back.sv -----
// Back end: polar conversion (squares, bit-serial square root, vectoring
// CORDIC), wheel state and event decision, output register. Uses twdt_pkg.
module twdt_back import twdt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  localparam int ENTRY_BITS = 2 + 2 * COORD_BITS + 2 * (COORD_BITS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  logic [ENTRY_BITS-1:0]    q_head,
  output logic                     q_pop,
  input  logic [RAD_BITS-1:0]      min_radius,
  input  logic [COORD_BITS-1:0]    wrap_line_y,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic [EV_BITS-1:0]       m_tuser
);

  localparam int CB       = COORD_BITS;
  localparam int DW       = CB + 1;
  localparam int RT_BITS  = CB + 1;
  localparam int SUM_BITS = 2 * RT_BITS;
  localparam int CNT_BITS = $clog2(RT_BITS + 1);
  localparam int XW       = CB + FRAC_BITS + 3;
  localparam int RW       = RT_BITS + RAD_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;

  logic [2:0] state;

  // Wheel state
  logic [CB-1:0]       prev_x, prev_y;
  logic [ANG_BITS-1:0] prev_wheel_angle, cur_angle;
  logic [RAD_BITS-1:0] cur_radius;
  logic                wheel_on;

  // Head of queue
  logic [1:0]    h_kind;
  logic [DW-1:0] h_dy, h_dx;
  logic [CB-1:0] h_py, h_px, h_ax, h_ay, h_a, h_b;
  logic          h_moved, h_polar;

  assign {h_kind, h_dy, h_dx, h_py, h_px} = q_head;
  assign h_ax    = h_dx[DW-1] ? CB'(~h_dx + 1'b1) : h_dx[CB-1:0];
  assign h_ay    = h_dy[DW-1] ? CB'(~h_dy + 1'b1) : h_dy[CB-1:0];
  assign h_a     = (h_ay > h_ax) ? h_ay : h_ax;
  assign h_b     = (h_ay > h_ax) ? h_ax : h_ay;
  assign h_moved = (h_px != prev_x) || (h_py != prev_y);
  assign h_polar = (h_kind == KIND_DOWN) || (h_kind == KIND_UP) ||
                   ((h_kind == KIND_MOVE) && h_moved);

  // Item registers
  logic [1:0]    kind;
  logic [CB-1:0] px, py, ax, ay;
  logic          dx_neg, dy_neg, swapped, polar;

  // Square root datapath
  logic [2*CB-1:0]     prod_x, prod_y;
  logic [SUM_BITS-1:0] sum_sh;
  logic [RT_BITS-1:0]  root, rem;
  logic [CNT_BITS-1:0] sq_cnt;
  logic [RT_BITS+1:0]  rem_raw, trial;
  logic                sqrt_done;

  assign rem_raw   = {rem, sum_sh[SUM_BITS-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign sqrt_done = (sq_cnt == CNT_BITS'(RT_BITS));

  // CORDIC datapath
  logic signed [XW-1:0] cx, cy, xs, ys;
  logic signed [ZW-1:0] cz, tab_z, z_cl, phi1, phi2;
  logic [STEP_BITS-1:0] step;
  logic                 cordic_done;

  assign xs          = cx >>> step;
  assign ys          = cy >>> step;
  assign tab_z       = $signed(ZW'(ATAN_TAB[step]));
  assign cordic_done = (step == STEP_BITS'(CORDIC_STEPS)) || (cy == '0);

  // Final angle and radius
  logic [7:0]          deg8;
  logic [ANG_BITS-1:0] ang_new;
  logic [RW-1:0]       root_ext;
  logic [RAD_BITS-1:0] rad_new;

  always_comb begin
    if (cz[ZW-1]) begin
      z_cl = '0;
    end else if (cz > $signed(ZW'(ATAN_TAB[0]))) begin
      z_cl = $signed(ZW'(ATAN_TAB[0]));
    end else begin
      z_cl = cz;
    end
    phi1 = swapped ? $signed(ZW'(QUARTER)) - z_cl : z_cl;
    phi2 = dx_neg ? $signed(ZW'(HALF)) - phi1 : phi1;
    deg8 = phi2[FRAC_BITS+7:FRAC_BITS];
    if (dy_neg && (deg8 != 8'd0)) begin
      ang_new = ANG_BITS'(ANGLE_FULL) - {1'b0, deg8};
    end else begin
      ang_new = {1'b0, deg8};
    end
    root_ext = RW'(root);
    rad_new  = (root_ext > RW'(RAD_MAX)) ? RAD_BITS'(RAD_MAX) : root_ext[RAD_BITS-1:0];
  end

  // Event decision on the updated angle and radius
  logic [EV_BITS-1:0] ev;
  logic               out_free, dir_hit, over_min;

  assign out_free = !m_tvalid || m_tready;
  assign over_min = (cur_radius > min_radius);
  assign dir_hit  = polar && (cur_angle != prev_wheel_angle) && over_min;

  always_comb begin
    ev = EV_NONE;
    case (kind)
      KIND_DOWN: if (over_min) ev = EV_ACTIVE;
      KIND_UP:   if (wheel_on) ev = EV_RELEASED;
      KIND_MOVE: begin
        if (dir_hit) begin
          if (cur_angle > prev_wheel_angle && py > wrap_line_y && py > prev_y) begin
            ev = EV_CCW;
          end else if (cur_angle < prev_wheel_angle && py < wrap_line_y &&
                       py < prev_y) begin
            ev = EV_CW;
          end else if (cur_angle > prev_wheel_angle) begin
            ev = EV_CCW;
          end else begin
            ev = EV_CW;
          end
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          kind    <= h_kind;
          px      <= h_px;
          py      <= h_py;
          ax      <= h_ax;
          ay      <= h_ay;
          dx_neg  <= h_dx[DW-1];
          dy_neg  <= h_dy[DW-1];
          swapped <= (h_ay > h_ax);
          polar   <= h_polar;
          cx      <= $signed(XW'({h_a, {FRAC_BITS{1'b0}}}));
          cy      <= $signed(XW'({h_b, {FRAC_BITS{1'b0}}}));
          cz      <= '0;
          step    <= '0;
        end
      end
      ST_SQR: begin
        prod_x <= ax * ax;
        prod_y <= ay * ay;
      end
      ST_SUM: begin
        sum_sh <= SUM_BITS'(prod_x) + SUM_BITS'(prod_y);
        root   <= '0;
        rem    <= '0;
        sq_cnt <= '0;
      end
      ST_RUN: begin
        if (!cordic_done) begin
          if (!cy[XW-1]) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + tab_z;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - tab_z;
          end
          step <= step + 1'b1;
        end
        if (!sqrt_done) begin
          if (rem_raw >= trial) begin
            rem  <= RT_BITS'(rem_raw - trial);
            root <= {root[RT_BITS-2:0], 1'b1};
          end else begin
            rem  <= RT_BITS'(rem_raw);
            root <= {root[RT_BITS-2:0], 1'b0};
          end
          sum_sh <= sum_sh << 2;
          sq_cnt <= sq_cnt + 1'b1;
        end
      end
      default: ;
    endcase
    if (state == ST_DEC && out_free) begin
      m_tuser <= ev;
      m_tdata <= OUT_DATA_BITS'({cur_radius, cur_angle});
    end
  end

  // Control and wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      prev_x           <= '0;
      prev_y           <= '0;
      prev_wheel_angle <= '0;
      cur_angle        <= '0;
      cur_radius       <= '0;
      wheel_on         <= 1'b0;
    end else begin
      if (state == ST_DEC && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (!q_empty) state <= h_polar ? ST_SQR : ST_DEC;
        ST_SQR:  state <= ST_SUM;
        ST_SUM:  state <= ST_RUN;
        ST_RUN:  if (cordic_done && sqrt_done) state <= ST_FIN;
        ST_FIN: begin
          cur_angle  <= ang_new;
          cur_radius <= rad_new;
          state      <= ST_DEC;
        end
        ST_DEC: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (polar) begin
              prev_x <= px;
              prev_y <= py;
            end
            if (kind == KIND_DOWN && over_min) begin
              prev_wheel_angle <= cur_angle;
              wheel_on         <= 1'b1;
            end
            if (kind == KIND_UP) begin
              wheel_on <= 1'b0;
            end
            if (kind == KIND_MOVE && dir_hit) begin
              prev_wheel_angle <= cur_angle;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/touch_wheel_direction_tracker.sv -----
// Touch wheel direction tracker, top level: configuration registers, front
// end, item queue and back end. Depends on twdt_pkg, twdt_front, twdt_queue, twdt_back.
// Path: a touch down, touch up or changed move passes from the queue through the
// squares, their sum, the shared CORDIC/square-root loop, final angle and radius and
// the event decision to m_tvalid; a repeated move or unknown opcode skips to the
// decision. The back end starts an item only once the last has reached m_tvalid.
// Reset (rst, synchronous): wheel state and queue cleared, registers to defaults.
module touch_wheel_direction_tracker import twdt_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  localparam int IN_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int CFG_BITS = (COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input items
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,   // x_pos, y_pos, zero pad
  input  logic [OP_BITS-1:0]        s_tuser,   // opcode
  // Result items
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_BITS-1:0]  m_tdata,   // angle_deg, radius_px, zero pad
  output logic [EV_BITS-1:0]        m_tuser,   // wheel_event
  // Configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  localparam int ENTRY_BITS = 2 + 2 * COORD_BITS + 2 * (COORD_BITS + 1);

  // Configuration registers; write them only while no item is in flight,
  // so no item sees a half-updated set.
  logic [COORD_BITS-1:0] center_x, center_y, wrap_line_y;
  logic [RAD_BITS-1:0]   min_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= COORD_BITS'(CENTER_RESET);
      center_y    <= COORD_BITS'(CENTER_RESET);
      min_radius  <= RAD_BITS'(MIN_RADIUS_RESET);
      wrap_line_y <= COORD_BITS'(WRAP_LINE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:    center_x    <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[COORD_BITS-1:0];
        REG_MIN_RADIUS:  min_radius  <= cfg_data[RAD_BITS-1:0];
        REG_WRAP_LINE_Y: wrap_line_y <= cfg_data[COORD_BITS-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Front end: classify and form center offsets
  logic                  q_push, q_full, q_pop, q_empty;
  logic [ENTRY_BITS-1:0] q_data, q_head;

  twdt_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .center_x (center_x),
    .center_y (center_y),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // Queue lets the front keep taking items while the back iterates
  twdt_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back end: polar conversion, wheel state, output register
  twdt_back #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .min_radius  (min_radius),
    .wrap_line_y (wrap_line_y),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

// ----- hdl/twdt_checker.sv -----
// Port-level checks of the touch wheel direction tracker's result stream,
// bound to the top level. Depends on twdt_pkg and touch_wheel_direction_tracker.
module twdt_checker import twdt_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic [EV_BITS-1:0]       m_tuser
);

  // Wheel activity as seen from delivered items
  logic on_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_seen <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (m_tuser == EV_ACTIVE) begin
        on_seen <= 1'b1;
      end else if (m_tuser == EV_RELEASED) begin
        on_seen <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ANG_BITS-1:0] < ANG_BITS'(ANGLE_FULL))
    else $error("angle out of range");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[ANG_BITS+RAD_BITS-1:ANG_BITS] == '0 |->
      m_tdata[ANG_BITS-1:0] == '0)
    else $error("zero radius with nonzero angle");

  a_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == EV_RELEASED |-> on_seen)
    else $error("release without prior activation");

endmodule

bind touch_wheel_direction_tracker twdt_checker u_twdt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for touch_wheel_direction_tracker: drives touch items and
// register writes, predicts each wheel result and compares it at the output.
// Depends on twdt_pkg and the touch_wheel_direction_tracker RTL.
module tb_top;
  import twdt_pkg::*;

  localparam int COORD_W       = COORD_BITS_DEF;
  localparam int IN_W          = ((2 * COORD_W + 7) / 8) * 8;
  localparam int CFG_W         = (COORD_W > RAD_BITS) ? COORD_W : RAD_BITS;
  localparam int COORD_TOP     = (1 << COORD_W) - 1;
  localparam int SETTLE_CYCLES = 30;
  localparam longint QUARTER_TURN = 64'd5898245;
  localparam longint HALF_TURN    = 64'd11796490;
  localparam logic [OP_BITS-1:0] OP_UNKNOWN = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd15;

  typedef struct {
    logic [EV_BITS-1:0]  ev;
    logic [ANG_BITS-1:0] ang;
    logic [RAD_BITS-1:0] rad;
  } wheel_result_t;

  // Tracks wheel state and registers, holds the predicted results in order.
  class wheel_scoreboard;
    logic [COORD_W-1:0]  cx, cy, wrap_y, last_x, last_y;
    logic [RAD_BITS-1:0] min_r, cur_rad;
    logic [ANG_BITS-1:0] wheel_ang, cur_ang;
    bit                  wheel_on;
    wheel_result_t       expected_q[$];
    int                  errors;
    int                  results_seen;

    function new();
      cx = COORD_W'(CENTER_RESET);
      cy = COORD_W'(CENTER_RESET);
      min_r = RAD_BITS'(MIN_RADIUS_RESET);
      wrap_y = COORD_W'(WRAP_LINE_RESET);
      last_x = '0;
      last_y = '0;
      wheel_ang = '0;
      cur_ang = '0;
      cur_rad = '0;
      wheel_on = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_CENTER_X:    cx = val[COORD_W-1:0];
        REG_CENTER_Y:    cy = val[COORD_W-1:0];
        REG_MIN_RADIUS:  min_r = val[RAD_BITS-1:0];
        REG_WRAP_LINE_Y: wrap_y = val[COORD_W-1:0];
        default: ;       // unknown index has no effect
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // atan(2^-i) in 2^-16 scaled degrees
    function longint arctan_step(int i);
      case (i)
        0:  return 2949122;
        1:  return 1740969;
        2:  return 919880;
        3:  return 466945;
        4:  return 234379;
        5:  return 117304;
        6:  return 58666;
        7:  return 29335;
        8:  return 14668;
        9:  return 7334;
        10: return 3667;
        11: return 1833;
        12: return 917;
        13: return 458;
        14: return 229;
        15: return 115;
        16: return 57;
        17: return 29;
        18: return 14;
        19: return 7;
        20: return 4;
        21: return 2;
        22: return 1;
        default: return 0;
      endcase
    endfunction

    // Polar angle and radius of a point about the center, into cur_ang/cur_rad
    function void locate_touch(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      int     dx, dy, ax, ay, a, b;
      longint sum, root, trial, x, y, z, nx, ny, phi, deg;
      bit     swapped;
      dx = int'(px) - int'(cx);
      dy = int'(cy) - int'(py);   // screen y points down
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sum = longint'(ax) * ax + longint'(ay) * ay;
      root = 0;
      for (int n = 12; n >= 0; n--) begin
        trial = root | (longint'(1) << n);
        if (trial * trial <= sum)
          root = trial;
      end
      if (root > RAD_MAX)
        cur_rad = RAD_BITS'(RAD_MAX);
      else
        cur_rad = root[RAD_BITS-1:0];
      if (sum == 0) begin
        cur_ang = '0;
        return;
      end
      swapped = ay > ax;
      a = swapped ? ay : ax;
      b = swapped ? ax : ay;
      x = longint'(a) <<< 16;
      y = longint'(b) <<< 16;
      z = 0;
      // vectoring rotations, floor shifts, stop early once y hits zero
      for (int i = 0; i < CORDIC_STEPS_DEF && i < TAB_LEN && y != 0; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z = z + arctan_step(i);
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z = z - arctan_step(i);
        end
        x = nx;
        y = ny;
      end
      if (z < 0)
        z = 0;
      if (z > arctan_step(0))
        z = arctan_step(0);
      phi = swapped ? QUARTER_TURN - z : z;
      if (dx < 0)
        phi = HALF_TURN - phi;
      deg = phi >>> 16;
      if (dy < 0 && deg != 0)
        deg = ANGLE_FULL - deg;
      cur_ang = deg[ANG_BITS-1:0];
    endfunction

    function void note_touch(logic [OP_BITS-1:0] op, logic [COORD_W-1:0] px,
                             logic [COORD_W-1:0] py);
      wheel_result_t r;
      r.ev = EV_NONE;
      case (op)
        OP_DOWN: begin
          locate_touch(px, py);
          last_x = px;
          last_y = py;
          if (cur_rad > min_r) begin
            r.ev = EV_ACTIVE;
            wheel_ang = cur_ang;
            wheel_on = 1'b1;
          end
        end
        OP_UP: begin
          locate_touch(px, py);
          last_x = px;
          last_y = py;
          if (wheel_on) begin
            r.ev = EV_RELEASED;
            wheel_on = 1'b0;
          end
        end
        OP_MOVE: begin
          // a move to the same point leaves everything alone
          if (px != last_x || py != last_y) begin
            locate_touch(px, py);
            // direction does not depend on wheel_on; the wrap line checks
            // always agree with the plain angle comparison
            if (cur_ang != wheel_ang && cur_rad > min_r) begin
              r.ev = (cur_ang > wheel_ang) ? EV_CCW : EV_CW;
              wheel_ang = cur_ang;
            end
            last_x = px;
            last_y = py;
          end
        end
        default: ;
      endcase
      r.ang = cur_ang;
      r.rad = cur_rad;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < 100)
        $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
      errors++;
    endtask

    task check_result(logic [EV_BITS-1:0] ev, logic [ANG_BITS-1:0] ang,
                      logic [RAD_BITS-1:0] rad);
      wheel_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result item with none expected");
      end else begin
        want = expected_q.pop_front();
        if (ev !== want.ev)
          report_mismatch($sformatf("wheel_event got %0d want %0d", ev, want.ev));
        if (ang !== want.ang)
          report_mismatch($sformatf("angle_deg got %0d want %0d", ang, want.ang));
        if (rad !== want.rad)
          report_mismatch($sformatf("radius_px got %0d want %0d", rad, want.rad));
      end
      results_seen++;
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_W-1:0]           s_tdata = '0;
  logic [OP_BITS-1:0]        s_tuser = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_tdata;
  logic [EV_BITS-1:0]        m_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  wheel_scoreboard sb = new();
  int sent_items = 0;
  int gap_pct = 20;     // chance in percent of a sender pause before an item
  int stall_pct = 20;   // chance in percent of a receiver stall burst
  int stall_left = 0;

  touch_wheel_direction_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: ready drops in random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[ANG_BITS-1:0], m_tdata[ANG_BITS +: RAD_BITS]);
  end

  function automatic logic [COORD_W-1:0] to_coord(int v);
    if (v < 0)
      return '0;
    if (v > COORD_TOP)
      return COORD_W'(COORD_TOP);
    return v[COORD_W-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_item(logic [OP_BITS-1:0] op, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y);
    int n;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      s_tdata <= IN_W'($urandom);
      s_tuser <= OP_BITS'($urandom);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(IN_W - 2 * COORD_W){1'b0}}, y, x};
    do @(posedge clk); while (!s_tready);
    sb.note_touch(op, x, y);
    sent_items++;
    @(negedge clk);
  endtask

  // Hold off input until every predicted result has come out, then settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_wheel(int cx, int cy, int min_r, int wrap_y);
    write_reg(REG_CENTER_X, CFG_W'(cx));
    write_reg(REG_CENTER_Y, CFG_W'(cy));
    write_reg(REG_MIN_RADIUS, CFG_W'(min_r));
    write_reg(REG_WRAP_LINE_Y, CFG_W'(wrap_y));
  endtask

  // Down, a walk of small moves (with some repeats), then up.
  task automatic run_gesture();
    int n, x, y;
    n = $urandom_range(2, 14);
    x = int'(sb.cx) + int'($urandom_range(0, 1000)) - 500;
    y = int'(sb.cy) + int'($urandom_range(0, 1000)) - 500;
    send_item(OP_DOWN, to_coord(x), to_coord(y));
    x = int'(to_coord(x));
    y = int'(to_coord(y));
    repeat (n) begin
      if ($urandom_range(0, 7) != 0) begin
        x = int'(to_coord(x + int'($urandom_range(0, 80)) - 40));
        y = int'(to_coord(y + int'($urandom_range(0, 80)) - 40));
      end
      send_item(OP_MOVE, COORD_W'(x), COORD_W'(y));
    end
    if ($urandom_range(0, 3) == 0)
      send_item(OP_UP, COORD_W'($urandom_range(0, COORD_TOP)),
                COORD_W'($urandom_range(0, COORD_TOP)));
    else
      send_item(OP_UP, COORD_W'(x), COORD_W'(y));
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n)
      send_item(OP_BITS'($urandom_range(0, 3)), COORD_W'($urandom_range(0, COORD_TOP)),
                COORD_W'($urandom_range(0, COORD_TOP)));
  endtask

  task automatic run_phase(int items, bit vary_pace);
    int stop_at;
    stop_at = sent_items + items;
    while (sent_items < stop_at) begin
      if (vary_pace) begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if ($urandom_range(0, 3) == 0)
        run_noise();
      else
        run_gesture();
    end
  endtask

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items at reset geometry: center 216,216, min radius 100
    send_item(OP_MOVE, 10'd0, 10'd0);          // same point as reset state
    send_item(OP_UNKNOWN, 10'd1023, 10'd1023);
    send_item(OP_DOWN, 10'd216, 10'd216);      // zero radius
    send_item(OP_UP, 10'd216, 10'd216);        // release while inactive
    send_item(OP_DOWN, 10'd416, 10'd216);      // active at 0 degrees
    send_item(OP_MOVE, 10'd216, 10'd16);       // 90
    send_item(OP_MOVE, 10'd16, 10'd216);       // 180
    send_item(OP_MOVE, 10'd216, 10'd416);      // 270
    send_item(OP_MOVE, 10'd415, 10'd220);      // just below +x
    send_item(OP_MOVE, 10'd416, 10'd216);      // wraps back to 0
    send_item(OP_MOVE, 10'd416, 10'd216);      // repeated point
    send_item(OP_MOVE, 10'd250, 10'd216);      // inside the dead zone
    send_item(OP_MOVE, 10'd316, 10'd216);      // radius equal to minimum
    send_item(OP_MOVE, 10'd317, 10'd216);
    send_item(OP_MOVE, 10'd317, 10'd210);
    send_item(OP_UP, 10'd0, 10'd0);
    send_item(OP_MOVE, 10'd216, 10'd0);        // direction while inactive
    send_item(OP_UP, 10'd1023, 10'd0);
    send_item(OP_DOWN, 10'd1023, 10'd1023);
    send_item(OP_MOVE, 10'd0, 10'd1023);
    send_item(OP_MOVE, 10'd0, 10'd0);
    send_item(OP_MOVE, 10'd1023, 10'd0);
    send_item(OP_UNKNOWN, 10'd0, 10'd0);
    send_item(OP_DOWN, 10'd216, 10'd116);      // radius equal to minimum
    send_item(OP_UP, 10'd1023, 10'd1023);
    drain_results();

    run_phase(250, 1'b1);
    drain_results();

    // Center in the corner, every touch away from the center counts
    set_wheel(0, 0, 0, 0);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    run_phase(125, 1'b1);
    drain_results();                           // sender waits for all results
    run_phase(125, 1'b1);
    drain_results();

    // Far corner, upper bits of the center writes dropped, wheel never counts
    set_wheel(11'h7FF, COORD_TOP, 2047, COORD_TOP);
    run_phase(150, 1'b1);
    drain_results();

    set_wheel($urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP),
              $urandom_range(0, 700), $urandom_range(0, COORD_TOP));
    run_phase(300, 1'b1);
    drain_results();

    // Closing stretch at full rate on both sides
    set_wheel(512, 300, 150, 700);
    gap_pct = 0;
    stall_pct = 0;
    run_phase(300, 1'b0);
    drain_results();

    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
